// File: hw/rtl/ftli_pkg.sv
// Shared types and constants of the file-transfer line interface.
`default_nettype none

package ftli_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_NAME   = 2'd1,
    PH_HEADER = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WORD_WR = 2'd1,
    REQ_BYTE_WR = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  localparam logic [1:0] OFF_RX_STATUS = 2'd0;
  localparam logic [1:0] OFF_RX_DATA   = 2'd1;
  localparam logic [1:0] OFF_TX_STATUS = 2'd2;
  localparam logic [1:0] OFF_TX_DATA   = 2'd3;

  localparam logic [7:0] CMD_STOP  = 8'd0;
  localparam logic [7:0] CMD_ECHO1 = 8'd1;
  localparam logic [7:0] CMD_LOAD  = 8'd2;
  localparam logic [7:0] CMD_ECHO3 = 8'd3;
  localparam logic [7:0] CMD_ECHO4 = 8'd4;

  localparam logic [15:0] READY_STATUS  = 16'o200;
  localparam logic [7:0]  UNKNOWN_REPLY = 8'o377;

  localparam int unsigned COUNT_W     = 17;
  localparam int unsigned HEADER_BYTES = 4;

endpackage

`default_nettype wire

// File: hw/rtl/file_transfer_line_interface_top.sv
// Top level of the file-transfer line interface: register window and phase machine.
//
//  channel | direction | ports                                            | handshake
//  --------+-----------+--------------------------------------------------+--------------
//  in      | to block  | in_req_type, in_reg_offset, in_write_data        | in_valid/in_stall
//  out     | from block| out_read_data, out_phase, out_transfer_address,  | out_valid/out_stall
//          |           | out_transfer_length, out_transfer_done           |
//
// One request per cycle sustained unless out_stall holds the result register; each result
// passes through the input register and then the result register before it appears.
// The phase machine state is updated when a request moves from the input register
// into the result register, so consecutive requests see each other's effects in order.
// rst_n (synchronous) returns to the idle phase with reply byte, count, address and
// length cleared. out_stall holds the result register and, once the input register
// is also full, raises in_stall.
`default_nettype none

module file_transfer_line_interface_top #(
  parameter int unsigned NAME_BYTES = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [1:0]          in_reg_offset,
  input  wire logic [15:0]         in_write_data,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [15:0]              out_read_data,
  output ftli_pkg::phase_t         out_phase,
  output logic [15:0]              out_transfer_address,
  output logic [15:0]              out_transfer_length,
  output logic                     out_transfer_done
);
  import ftli_pkg::*;

  // input register
  logic             s1_valid_r;
  logic [1:0]       s1_req_r;
  logic [1:0]       s1_off_r;
  logic [7:0]       s1_byte_r;

  // result register
  logic             out_valid_r;
  logic [15:0]      out_read_data_r;
  phase_t           out_phase_r;
  logic             out_done_r;

  // phase machine state
  phase_t               phase_r, phase_nxt;
  logic [7:0]           reply_r, reply_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [15:0]          addr_r, addr_nxt;
  logic [15:0]          len_r, len_nxt;

  logic                 s2_ready;
  logic                 s1_fire;
  logic                 feed;
  logic [COUNT_W-1:0]   count_inc;
  logic                 name_end;
  logic                 header_end;
  logic                 body_end;
  logic                 done;
  logic [15:0]          rd;

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;

  assign feed = (s1_req_r == REQ_BYTE_WR) ||
                ((s1_req_r == REQ_WORD_WR) && (s1_off_r == OFF_TX_DATA));

  assign count_inc  = count_r + COUNT_W'(1);
  assign name_end   = count_inc >= COUNT_W'(NAME_BYTES);
  assign header_end = count_inc >= COUNT_W'(HEADER_BYTES);
  // a zero length never matches, so the body phase runs on
  assign body_end   = (len_r != 16'd0) && (count_inc == {1'b0, len_r});

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (feed) begin
      unique case (phase_r)
        PH_IDLE:   if (s1_byte_r == CMD_LOAD) phase_nxt = PH_NAME;
        PH_NAME:   if (name_end) phase_nxt = PH_HEADER;
        PH_HEADER: if (header_end) phase_nxt = PH_BODY;
        PH_BODY:   if (body_end) phase_nxt = PH_IDLE;
        default:   phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath updates per phase
  always_comb begin
    reply_nxt = reply_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    done      = 1'b0;
    if (feed) begin
      unique case (phase_r)
        PH_IDLE: begin
          case (s1_byte_r) inside
            CMD_STOP: ;
            CMD_ECHO1, CMD_ECHO3, CMD_ECHO4: reply_nxt = s1_byte_r;
            CMD_LOAD: begin
              reply_nxt = s1_byte_r;
              count_nxt = '0;
            end
            default: reply_nxt = UNKNOWN_REPLY;
          endcase
        end
        PH_NAME: begin
          reply_nxt = 8'd0;
          count_nxt = name_end ? '0 : count_inc;
        end
        PH_HEADER: begin
          case (count_r[1:0])
            2'd0:    addr_nxt = {8'd0, s1_byte_r};
            2'd1:    addr_nxt = {addr_r[15:8] | s1_byte_r, addr_r[7:0]};
            2'd2:    len_nxt  = {8'd0, s1_byte_r};
            default: len_nxt  = {len_r[15:8] | s1_byte_r, len_r[7:0]};
          endcase
          count_nxt = header_end ? '0 : count_inc;
        end
        PH_BODY: begin
          count_nxt = body_end ? '0 : count_inc;
          done      = body_end;
        end
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    rd = 16'd0;
    if (s1_req_r == REQ_READ) begin
      unique case (s1_off_r) inside
        OFF_RX_STATUS, OFF_TX_STATUS: rd = READY_STATUS;
        OFF_RX_DATA:                  rd = {8'd0, reply_r};
        default:                      rd = 16'd0;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      reply_r     <= 8'd0;
      count_r     <= '0;
      addr_r      <= 16'd0;
      len_r       <= 16'd0;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (s2_ready)  out_valid_r <= s1_valid_r;
      if (s1_fire) begin
        phase_r <= phase_nxt;
        reply_r <= reply_nxt;
        count_r <= count_nxt;
        addr_r  <= addr_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_req_r  <= in_req_type;
      s1_off_r  <= in_reg_offset;
      s1_byte_r <= in_write_data[7:0];
    end
    if (s1_fire) begin
      out_read_data_r <= rd;
      out_phase_r     <= phase_nxt;
      out_done_r      <= done;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_read_data        = out_read_data_r;
  assign out_phase            = out_phase_r;
  assign out_transfer_done    = out_done_r;
  // address and length follow the state, which only moves when the result register loads
  assign out_transfer_address = addr_r;
  assign out_transfer_length  = len_r;

endmodule

`default_nettype wire

// File: hw/rtl/ftli_checker.sv
// Port-level checker for the file-transfer line interface, bound to the top level.
`default_nettype none

module ftli_port_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [15:0]       out_read_data,
  input wire ftli_pkg::phase_t  out_phase,
  input wire logic [15:0]       out_transfer_address,
  input wire logic [15:0]       out_transfer_length,
  input wire logic              out_transfer_done
);
  import ftli_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) &&
      $stable(out_phase) && $stable(out_transfer_done))
    else $error("result changed while stalled");

  // end of body always lands in idle and needs a nonzero length
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_transfer_done |->
      out_phase == PH_IDLE && out_transfer_length != 16'd0)
    else $error("transfer end outside idle or with zero length");

  // nothing left over across reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // header fields only move while a request is being processed
  a_fields_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_valid) && !$past(out_valid) && !out_valid |->
      $stable(out_transfer_address) && $stable(out_transfer_length))
    else $error("header fields changed with no request in flight");

endmodule

bind file_transfer_line_interface_top ftli_port_checker u_ftli_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_read_data        (out_read_data),
  .out_phase            (out_phase),
  .out_transfer_address (out_transfer_address),
  .out_transfer_length  (out_transfer_length),
  .out_transfer_done    (out_transfer_done)
);

`default_nettype wire

// File: tb/ftli_checker.sv
// Predicts each register-window request of the file-transfer line and checks the result stream.
`default_nettype none

module ftli_checker #(
  parameter int unsigned NAME_BYTES = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [1:0]       in_reg_offset,
  input  wire logic [15:0]      in_write_data,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire logic [15:0]      out_read_data,
  input  ftli_pkg::phase_t      out_phase,
  input  wire logic [15:0]      out_transfer_address,
  input  wire logic [15:0]      out_transfer_length,
  input  wire logic             out_transfer_done,
  output int                    mismatches,
  output int                    pending,
  output int                    transfers_done
);
  timeunit 1ns;
  timeprecision 1ps;
  import ftli_pkg::*;

  typedef struct packed {
    logic [15:0] read_data;
    phase_t      phase;
    logic [15:0] address;
    logic [15:0] length;
    logic        done;
  } access_result_t;

  access_result_t      window_results_q[$];
  phase_t              phase_q;
  logic [7:0]          reply_q;
  logic [COUNT_W-1:0]  count_q;
  logic [15:0]         addr_q;
  logic [15:0]         len_q;
  int                  fail_n;
  int                  checked_n;
  int                  done_n;

  // One command byte through the phase machine; returns 1 when a body completes.
  function automatic logic feed_command(input logic [7:0] b);
    logic done;
    done = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (b == CMD_STOP) begin
          // reply byte kept
        end else if (b == CMD_ECHO1 || b == CMD_ECHO3 || b == CMD_ECHO4) begin
          reply_q = b;
        end else if (b == CMD_LOAD) begin
          reply_q = b;
          phase_q = PH_NAME;
          count_q = '0;
        end else begin
          reply_q = UNKNOWN_REPLY;
        end
      end
      PH_NAME: begin
        reply_q = 8'h00;
        count_q = count_q + 1'b1;
        if (count_q >= NAME_BYTES) begin
          phase_q = PH_HEADER;
          count_q = '0;
        end
      end
      PH_HEADER: begin
        case (count_q)
          0: addr_q = {8'h00, b};
          1: addr_q = addr_q | {b, 8'h00};
          2: len_q = {8'h00, b};
          default: len_q = len_q | {b, 8'h00};
        endcase
        count_q = count_q + 1'b1;
        if (count_q >= HEADER_BYTES) begin
          phase_q = PH_BODY;
          count_q = '0;
        end
      end
      default: begin
        // zero length never matches, so the body stays open
        count_q = count_q + 1'b1;
        if (len_q != 16'h0000 && count_q == {1'b0, len_q}) begin
          phase_q = PH_IDLE;
          count_q = '0;
          done = 1'b1;
        end
      end
    endcase
    return done;
  endfunction

  function automatic access_result_t predict_access(input req_t req, input logic [1:0] off,
                                                    input logic [15:0] data);
    access_result_t r;
    r.read_data = 16'h0000;
    r.done = 1'b0;
    case (req)
      REQ_READ: begin
        if (off == OFF_RX_STATUS || off == OFF_TX_STATUS) begin
          r.read_data = READY_STATUS;
        end else if (off == OFF_RX_DATA) begin
          r.read_data = {8'h00, reply_q};
        end
      end
      REQ_WORD_WR: begin
        if (off == OFF_TX_DATA) begin
          r.done = feed_command(data[7:0]);
        end
      end
      REQ_BYTE_WR: begin
        r.done = feed_command(data[7:0]);
      end
      default: begin
      end
    endcase
    r.phase = phase_q;
    r.address = addr_q;
    r.length = len_q;
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t seen;
    access_result_t want;
    if (!rst_n) begin
      phase_q = PH_IDLE;
      reply_q = 8'h00;
      count_q = '0;
      addr_q = 16'h0000;
      len_q = 16'h0000;
      fail_n = 0;
      checked_n = 0;
      done_n = 0;
      window_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.read_data = out_read_data;
        seen.phase = out_phase;
        seen.address = out_transfer_address;
        seen.length = out_transfer_length;
        seen.done = out_transfer_done;
        if (window_results_q.size() == 0) begin
          fail_n++;
          if (fail_n <= 10) begin
            $display("ERROR: result with no request outstanding: rd=%h phase=%0d addr=%h len=%h done=%b",
                     seen.read_data, seen.phase, seen.address, seen.length, seen.done);
          end
        end else begin
          want = window_results_q.pop_front();
          if (seen.read_data !== want.read_data || seen.phase !== want.phase ||
              seen.address !== want.address || seen.length !== want.length ||
              seen.done !== want.done) begin
            fail_n++;
            if (fail_n <= 10) begin
              $display("ERROR: result %0d: expected rd=%h phase=%0d addr=%h len=%h done=%b",
                       checked_n, want.read_data, want.phase, want.address, want.length,
                       want.done);
              $display("       got      rd=%h phase=%0d addr=%h len=%h done=%b",
                       seen.read_data, seen.phase, seen.address, seen.length, seen.done);
            end
          end
        end
        checked_n++;
      end
      if (in_valid && !in_stall) begin
        want = predict_access(req_t'(in_req_type), in_reg_offset, in_write_data);
        if (want.done) done_n++;
        window_results_q.push_back(want);
      end
    end
    mismatches <= fail_n;
    pending <= window_results_q.size();
    transfers_done <= done_n;
  end

endmodule

`default_nettype wire

// File: tb/file_transfer_line_interface_top_tb.sv
// Stimulus, clocking and verdict for the file-transfer line interface.
`default_nettype none

module file_transfer_line_interface_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ftli_pkg::*;

  localparam int unsigned NAME_LEN = 10;
  localparam int REQUEST_TARGET = 1650;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_req_type;
  logic [1:0]       in_reg_offset;
  logic [15:0]      in_write_data;
  logic             out_valid;
  logic             out_stall;
  logic [15:0]      out_read_data;
  phase_t           out_phase;
  logic [15:0]      out_transfer_address;
  logic [15:0]      out_transfer_length;
  logic             out_transfer_done;

  int               mismatches;
  int               pending;
  int               transfers_done;
  int               requests_sent;
  int               quiet_cycles;
  logic             calm;
  logic             paused;

  file_transfer_line_interface_top #(
    .NAME_BYTES(NAME_LEN)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_reg_offset       (in_reg_offset),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_phase           (out_phase),
    .out_transfer_address(out_transfer_address),
    .out_transfer_length (out_transfer_length),
    .out_transfer_done   (out_transfer_done)
  );

  ftli_checker #(
    .NAME_BYTES(NAME_LEN)
  ) access_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_reg_offset       (in_reg_offset),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_phase           (out_phase),
    .out_transfer_address(out_transfer_address),
    .out_transfer_length (out_transfer_length),
    .out_transfer_done   (out_transfer_done),
    .mismatches          (mismatches),
    .pending             (pending),
    .transfers_done      (transfers_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  // Watchdog: no request or result moving for too long ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input req_t req, input logic [1:0] off, input logic [15:0] data);
    if (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      in_req_type <= 2'($urandom_range(3));
      in_reg_offset <= 2'($urandom_range(3));
      in_write_data <= 16'($urandom_range(16'hFFFF));
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_reg_offset <= off;
    in_write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(req == REQ_NONE || (req == REQ_WORD_WR && off != OFF_TX_DATA))) requests_sent++;
  endtask

  // Reads, unknown request types and word writes that miss the transmit data word.
  task automatic send_noise;
    logic [1:0]  off;
    logic [15:0] data;
    int          pick;
    off = 2'($urandom_range(3));
    data = 16'($urandom_range(16'hFFFF));
    pick = $urandom_range(9);
    if (pick < 6) begin
      send_req(REQ_READ, off, data);
    end else if (pick < 8) begin
      send_req(REQ_WORD_WR, (off == OFF_TX_DATA) ? OFF_RX_DATA : off, data);
    end else begin
      send_req(REQ_NONE, off, data);
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    logic [1:0] off;
    logic [7:0] hi;
    off = 2'($urandom_range(3));
    hi = 8'($urandom_range(255));
    if ($urandom_range(99) < 15) send_noise();
    if ($urandom_range(1)) begin
      send_req(REQ_BYTE_WR, off, {hi, b});
    end else begin
      send_req(REQ_WORD_WR, OFF_TX_DATA, {hi, b});
    end
  endtask

  // Idle-phase command that never opens a load.
  task automatic idle_command;
    logic [7:0] b;
    if ($urandom_range(9) < 6) begin
      b = 8'($urandom_range(3));
      if (b == CMD_LOAD) b = CMD_ECHO4;
    end else begin
      b = 8'($urandom_range(5, 255));
    end
    push_byte(b);
  endtask

  task automatic run_load(input logic [15:0] addr, input logic [15:0] len, input int body_n);
    push_byte(CMD_LOAD);
    repeat (NAME_LEN) push_byte(8'($urandom_range(255)));
    push_byte(addr[7:0]);
    push_byte(addr[15:8]);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    repeat (body_n) push_byte(8'($urandom_range(255)));
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] len;
    int          pick;
    requests_sent = 0;
    quiet_cycles = 0;
    paused = 1'b0;
    calm <= 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_READ;
    in_reg_offset <= OFF_RX_STATUS;
    in_write_data <= 16'h0000;
    out_stall <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_req(REQ_READ, OFF_RX_STATUS, 16'h0000);
    send_req(REQ_READ, OFF_RX_DATA, 16'hFFFF);
    send_req(REQ_READ, OFF_TX_STATUS, 16'h0000);
    send_req(REQ_READ, OFF_TX_DATA, 16'hFFFF);
    send_req(REQ_NONE, OFF_TX_DATA, 16'hFFFF);
    send_req(REQ_WORD_WR, OFF_RX_STATUS, 16'hFFFF);
    send_req(REQ_WORD_WR, OFF_RX_DATA, 16'h0001);
    send_req(REQ_WORD_WR, OFF_TX_STATUS, 16'h00FF);
    send_req(REQ_READ, OFF_RX_DATA, 16'h0000);
    send_req(REQ_BYTE_WR, OFF_RX_STATUS, {8'hFF, CMD_ECHO1});
    send_req(REQ_READ, OFF_RX_DATA, 16'h0000);
    send_req(REQ_WORD_WR, OFF_TX_DATA, {8'hA5, CMD_ECHO3});
    send_req(REQ_READ, OFF_RX_DATA, 16'h0000);
    send_req(REQ_BYTE_WR, OFF_TX_STATUS, 16'h00FF);
    send_req(REQ_READ, OFF_RX_DATA, 16'h0000);
    send_req(REQ_BYTE_WR, OFF_RX_DATA, {8'h5A, CMD_STOP});
    send_req(REQ_READ, OFF_RX_DATA, 16'h0000);
    send_req(REQ_BYTE_WR, OFF_TX_DATA, {8'h00, CMD_ECHO4});
    send_req(REQ_READ, OFF_RX_DATA, 16'h0000);
    send_req(REQ_BYTE_WR, OFF_RX_DATA, 16'h0005);
    send_req(REQ_READ, OFF_RX_DATA, 16'h0000);

    run_load(16'hFFFF, 16'h0001, 1);
    run_load(16'h0000, 16'h0100, 256);

    while (requests_sent < REQUEST_TARGET) begin
      calm <= (requests_sent >= 300 && requests_sent < 500);
      if (!paused && requests_sent >= 800) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        pick = $urandom_range(99);
        if (pick < 90) len = 16'($urandom_range(1, 12));
        else if (pick < 97) len = 16'($urandom_range(13, 64));
        else len = 16'($urandom_range(256, 300));
        run_load(16'($urandom_range(16'hFFFF)), len, int'(len));
      end else if (pick < 80) begin
        idle_command();
      end else begin
        send_noise();
      end
    end

    // zero length leaves the body phase open for good, so it goes last
    run_load(16'($urandom_range(16'hFFFF)), 16'h0000, 40);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d window requests with %0d completed load transfers,",
             requests_sent, transfers_done);
    $display("idle commands, reads, ignored writes and a final zero-length body.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
